FILE: rtl/core/sha1_pkg.sv
// Shared types, constants and round functions of the SHA-1 hash engine.
package sha1_pkg;

   // Five 32-bit words: chain value or working variables, word 0 lowest.
   typedef logic [4:0][31:0] word5_type;

   // Initial chain value h0..h4.
   localparam word5_type H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                   32'hEFCDAB89, 32'h67452301};

   // Round constants, one per group of twenty rounds.
   localparam logic [31:0] K_GRP0 = 32'h5A827999;
   localparam logic [31:0] K_GRP1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_GRP2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_GRP3 = 32'hCA62C1D6;

   // Padding marker byte and the index of the last round of a block.
   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [6:0] LAST_ROUND = 7'd79;

   // Control from the sequencer to the round unit.
   typedef struct packed {
      logic       round_en;   // one round of compression this cycle
      logic       first;      // first round: take the chain value as a..e
      logic       fold;       // add the working variables into the chain
      logic       init;       // return the chain to its initial value
   } round_ctl_type;

   // Boolean function of round t.
   function automatic logic [31:0] sha1_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
      logic [31:0] r;
      if (t < 7'd20) begin
         r = (b & c) | (~b & d);
      end else if (t < 7'd40) begin
         r = b ^ c ^ d;
      end else if (t < 7'd60) begin
         r = (b & c) | (b & d) | (c & d);
      end else begin
         r = b ^ c ^ d;
      end
      return r;
   endfunction

   // Additive constant of round t.
   function automatic logic [31:0] sha1_k(input logic [6:0] t);
      logic [31:0] r;
      if (t < 7'd20) begin
         r = K_GRP0;
      end else if (t < 7'd40) begin
         r = K_GRP1;
      end else if (t < 7'd60) begin
         r = K_GRP2;
      end else begin
         r = K_GRP3;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/sha1_sched_cell.sv
// One 32-bit cell of the message schedule shift chain.
module sha1_sched_cell
   import sha1_pkg::*;
(
   input  logic        clock,
   input  logic        shift_en,
   input  logic [31:0] word_in,
   output logic [31:0] word_out
);

   logic [31:0] word_ff;
   logic [31:0] word_in_mux;

   // Take the neighbor's word on a shift, hold otherwise.
   assign word_in_mux = shift_en ? word_in : word_ff;

   always_ff @(posedge clock) begin
      word_ff <= word_in_mux;
   end

   assign word_out = word_ff;

endmodule

FILE: rtl/core/sha1_round.sv
// SHA-1 round unit: working variables a..e and the chain value h0..h4.
module sha1_round
   import sha1_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  round_ctl_type ctl,
   input  logic [6:0]    rnd,
   input  logic [31:0]   wt,
   output word5_type     chain
);

   word5_type   work_ff;
   word5_type   chain_ff;
   word5_type   cur;
   logic [31:0] tmp;

   // The first round starts from the chain value.
   assign cur = ctl.first ? chain_ff : work_ff;

   assign tmp = {cur[0][26:0], cur[0][31:27]} + sha1_f(rnd, cur[1], cur[2], cur[3])
                + cur[4] + sha1_k(rnd) + wt;

   // Working variables rotate down by one each round.
   always_ff @(posedge clock) begin
      if (ctl.round_en) begin
         work_ff[4] <= cur[3];
         work_ff[3] <= cur[2];
         work_ff[2] <= {cur[1][1:0], cur[1][31:2]};
         work_ff[1] <= cur[0];
         work_ff[0] <= tmp;
      end
   end

   // Chain value: fold after each block, back to the initial value after a digest.
   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         chain_ff <= H_INIT;
      end else if (ctl.fold) begin
         for (int i = 0; i < 5; i++) begin
            chain_ff[i] <= chain_ff[i] + work_ff[i];
         end
      end
   end

   assign chain = chain_ff;

endmodule

FILE: rtl/core/sha1_hash_engine.sv
// Top level of the SHA-1 hash engine: byte intake, padding, sequencing, digest output.
//
//   channel  direction  tdata                tuser              tlast
//   req_     in         [7:0] data_byte      byte_valid         last_item
//   rsp_     out        [31:0] digest_word   [2:0] word_index   last_word
//
// Bytes are taken back to back while the input is ready; each full 64-byte block
// then holds the input through 80 rounds in the shared round unit and one fold.
// A last transaction adds a word load per padding word, one or two more blocks,
// then five digest transactions.
// Reset clears the sequencer and loads the initial chain value.
// The input is ready only while loading, not while padding, compressing, folding
// or sending the digest; a stalled digest transaction holds its word until taken.
module sha1_hash_engine
   import sha1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // byte_valid
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast
);

   typedef enum logic [4:0] {
      S_LOAD  = 5'b00001,
      S_PAD   = 5'b00010,
      S_ROUND = 5'b00100,
      S_FOLD  = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic [6:0]    rnd_ff, rnd_in;
   logic [3:0]    wcnt_ff, wcnt_in;
   logic [1:0]    bphase_ff, bphase_in;
   logic [23:0]   acc_ff, acc_in;
   logic [60:0]   count_ff, count_in;
   logic          fin_ff, fin_in;
   logic          mark_ff, mark_in;
   logic          blk2_ff, blk2_in;
   logic          len_ff, len_in;
   logic [2:0]    idx_ff, idx_in;

   logic          req_fire;
   logic          rsp_fire;
   logic          push;
   logic [31:0]   push_word;
   logic [31:0]   mark_word;
   logic          shift_en;
   logic [31:0]   new_word;
   logic [31:0]   sched [16];
   round_ctl_type ctl;
   word5_type     chain;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == S_LOAD);

   // Word holding the bytes so far of the partial word and the marker byte.
   always_comb begin
      case (bphase_ff)
         2'd0:    mark_word = {PAD_MARK, 24'd0};
         2'd1:    mark_word = {acc_ff[7:0], PAD_MARK, 16'd0};
         2'd2:    mark_word = {acc_ff[15:0], PAD_MARK, 8'd0};
         2'd3:    mark_word = {acc_ff[23:0], PAD_MARK};
         default: mark_word = {PAD_MARK, 24'd0};
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      rnd_in    = rnd_ff;
      bphase_in = bphase_ff;
      acc_in    = acc_ff;
      count_in  = count_ff;
      fin_in    = fin_ff;
      mark_in   = mark_ff;
      blk2_in   = blk2_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      push      = 1'b0;
      push_word = '0;
      ctl       = '0;
      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (req_tuser) begin
                  acc_in    = {acc_ff[15:0], req_tdata};
                  bphase_in = bphase_ff + 2'd1;
                  count_in  = count_ff + 61'd1;
                  if (bphase_ff == 2'd3) begin
                     push      = 1'b1;
                     push_word = {acc_ff, req_tdata};
                  end
               end
               if (req_tlast) begin
                  fin_in  = 1'b1;
                  mark_in = 1'b1;
               end
               if (push && (wcnt_ff == 4'd15)) begin
                  state_in = S_ROUND;
               end else if (req_tlast) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            push = 1'b1;
            if (mark_ff) begin
               push_word = mark_word;
               mark_in   = 1'b0;
               if (wcnt_ff == 4'd14) begin
                  blk2_in = 1'b1;
               end
            end else if (blk2_ff || (wcnt_ff < 4'd14)) begin
               push_word = '0;
            end else if (wcnt_ff == 4'd14) begin
               push_word = count_ff[60:29];
            end else begin
               push_word = {count_ff[28:0], 3'd0};
               len_in    = 1'b1;
            end
            if (wcnt_ff == 4'd15) begin
               blk2_in  = 1'b0;
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            ctl.round_en = 1'b1;
            ctl.first    = (rnd_ff == 7'd0);
            rnd_in       = rnd_ff + 7'd1;
            if (rnd_ff == LAST_ROUND) begin
               rnd_in   = 7'd0;
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            ctl.fold = 1'b1;
            if (len_ff) begin
               state_in = S_OUT;
            end else if (fin_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_OUT: begin
            if (rsp_fire) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd4) begin
                  ctl.init  = 1'b1;
                  idx_in    = 3'd0;
                  count_in  = '0;
                  bphase_in = 2'd0;
                  fin_in    = 1'b0;
                  len_in    = 1'b0;
                  state_in  = S_LOAD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   assign wcnt_in = wcnt_ff + {3'd0, push};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         rnd_ff    <= '0;
         wcnt_ff   <= '0;
         bphase_ff <= '0;
         count_ff  <= '0;
         fin_ff    <= 1'b0;
         mark_ff   <= 1'b0;
         blk2_ff   <= 1'b0;
         len_ff    <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         rnd_ff    <= rnd_in;
         wcnt_ff   <= wcnt_in;
         bphase_ff <= bphase_in;
         count_ff  <= count_in;
         fin_ff    <= fin_in;
         mark_ff   <= mark_in;
         blk2_ff   <= blk2_in;
         len_ff    <= len_in;
         idx_ff    <= idx_in;
      end
   end

   // Partial word of bytes; payload only.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Schedule chain: cell 0 holds w[t], cell 15 takes the newest word.
   assign shift_en = push || ctl.round_en;
   assign new_word = ctl.round_en
                     ? {sched[13][30:0] ^ sched[8][30:0] ^ sched[2][30:0] ^ sched[0][30:0],
                        sched[13][31] ^ sched[8][31] ^ sched[2][31] ^ sched[0][31]}
                     : push_word;

   for (genvar g = 0; g < 16; g++) begin : g_cell
      sha1_sched_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .word_in  ((g == 15) ? new_word : sched[(g + 1) % 16]),
         .word_out (sched[g])
      );
   end

   sha1_round u_round (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .rnd   (rnd_ff),
      .wt    (sched[0]),
      .chain (chain)
   );

   // Digest output straight from the chain registers.
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = chain[idx_ff];
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == 3'd4);

   // The round counter only moves while a block compresses.
   a_rnd_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_ROUND) |-> (rnd_ff == 7'd0))
      else $error("round counter left nonzero outside compression");

   // A block starts compressing only with all sixteen words loaded.
   a_block_full: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_ROUND) && (rnd_ff == 7'd0)) |-> (wcnt_ff == 4'd0))
      else $error("compression started on a partial block");

   // Padding runs only for a message that has ended.
   a_pad_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAD) |-> (fin_ff && !len_ff))
      else $error("padding outside a finished message");

   // After the fifth digest word the engine is back to an empty message.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> ((count_ff == 61'd0) && (chain == H_INIT)))
      else $error("engine did not restart after the digest");

endmodule
